// ===== design/acte_pkg.sv =====
// Shared types, constants and register codes for the alarm clock tick engine.
`timescale 1ns / 1ps
`default_nettype none

package acte_pkg;

    // Default divider length in ticks per second
    localparam int TICKS_PER_SECOND_DEF = 64;

    // Field widths
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int COUNT_W  = 8;
    localparam int LIGHT_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // Seconds and minutes wrap here
    localparam logic [6:0] SIXTY = 7'd60;

    // Output queue depth
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 2;

    // Operation codes carried in tuser
    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_SET_TIME = 1'b1
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_HOUR    = 3'd0,
        CFG_ALARM_MINUTE  = 3'd1,
        CFG_MOTOR_SECONDS = 3'd2,
        CFG_LAMP_SECONDS  = 3'd3,
        CFG_LIGHT_THRESH  = 3'd4,
        CFG_LIGHT_HYST    = 3'd5,
        CFG_HOUR_MAX      = 3'd6,
        CFG_HOUR_MIN      = 3'd7
    } t_cfg_idx;

    // Configuration register reset values
    localparam logic [HOUR_W-1:0]  RST_ALARM_HOUR    = 5'd6;
    localparam logic [MIN_W-1:0]   RST_ALARM_MINUTE  = 6'd0;
    localparam logic [COUNT_W-1:0] RST_MOTOR_SECONDS = 8'd30;
    localparam logic [COUNT_W-1:0] RST_LAMP_SECONDS  = 8'd60;
    localparam logic [LIGHT_W-1:0] RST_LIGHT_THRESH  = 10'd512;
    localparam logic [LIGHT_W-1:0] RST_LIGHT_HYST    = 10'd16;
    localparam logic [HOUR_W-1:0]  RST_HOUR_MAX      = 5'd23;
    localparam logic [HOUR_W-1:0]  RST_HOUR_MIN      = 5'd0;

    typedef struct packed {
        logic [HOUR_W-1:0]  alarm_hour;
        logic [MIN_W-1:0]   alarm_minute;
        logic [COUNT_W-1:0] motor_seconds;
        logic [COUNT_W-1:0] lamp_seconds;
        logic [LIGHT_W-1:0] light_threshold;
        logic [LIGHT_W-1:0] light_hysteresis;
        logic [HOUR_W-1:0]  hour_max;
        logic [HOUR_W-1:0]  hour_min;
    } t_cfg;

    typedef struct packed {
        t_op                operation;
        logic [LIGHT_W-1:0] sense_sample;
        logic [HOUR_W-1:0]  new_hour;
        logic [MIN_W-1:0]   new_minute;
        logic [SEC_W-1:0]   new_second;
    } t_item;

    typedef struct packed {
        logic               second_pulse;
        logic               half_second_pulse;
        logic               lamp_drive;
        logic               motor_drive;
        logic [SEC_W-1:0]   second_now;
        logic [MIN_W-1:0]   minute_now;
        logic [HOUR_W-1:0]  hour_now;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

// ===== design/acte_cfg_regs.sv =====
// Configuration register file for the alarm clock tick engine.
`timescale 1ns / 1ps
`default_nettype none

module acte_cfg_regs (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [acte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [acte_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output acte_pkg::t_cfg                    o_cfg
);

    acte_pkg::t_cfg r_cfg;
    acte_pkg::t_cfg n_cfg;

    // Writes are taken every cycle
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (acte_pkg::t_cfg_idx'(i_cfg_index))
                acte_pkg::CFG_ALARM_HOUR:
                    n_cfg.alarm_hour = i_cfg_data[acte_pkg::HOUR_W-1:0];
                acte_pkg::CFG_ALARM_MINUTE:
                    n_cfg.alarm_minute = i_cfg_data[acte_pkg::MIN_W-1:0];
                acte_pkg::CFG_MOTOR_SECONDS:
                    n_cfg.motor_seconds = i_cfg_data[acte_pkg::COUNT_W-1:0];
                acte_pkg::CFG_LAMP_SECONDS:
                    n_cfg.lamp_seconds = i_cfg_data[acte_pkg::COUNT_W-1:0];
                acte_pkg::CFG_LIGHT_THRESH:
                    n_cfg.light_threshold = i_cfg_data[acte_pkg::LIGHT_W-1:0];
                acte_pkg::CFG_LIGHT_HYST:
                    n_cfg.light_hysteresis = i_cfg_data[acte_pkg::LIGHT_W-1:0];
                acte_pkg::CFG_HOUR_MAX:
                    n_cfg.hour_max = i_cfg_data[acte_pkg::HOUR_W-1:0];
                acte_pkg::CFG_HOUR_MIN:
                    n_cfg.hour_min = i_cfg_data[acte_pkg::HOUR_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_hour       <= acte_pkg::RST_ALARM_HOUR;
            r_cfg.alarm_minute     <= acte_pkg::RST_ALARM_MINUTE;
            r_cfg.motor_seconds    <= acte_pkg::RST_MOTOR_SECONDS;
            r_cfg.lamp_seconds     <= acte_pkg::RST_LAMP_SECONDS;
            r_cfg.light_threshold  <= acte_pkg::RST_LIGHT_THRESH;
            r_cfg.light_hysteresis <= acte_pkg::RST_LIGHT_HYST;
            r_cfg.hour_max         <= acte_pkg::RST_HOUR_MAX;
            r_cfg.hour_min         <= acte_pkg::RST_HOUR_MIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== design/acte_step.sv =====
// Input register, time-of-day state and one-item update logic.
`timescale 1ns / 1ps
`default_nettype none

module acte_step #(
    parameter int TICKS_PER_SECOND = acte_pkg::TICKS_PER_SECOND_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_accept,
    input  acte_pkg::t_item     i_item,
    input  acte_pkg::t_cfg      i_cfg,
    output logic                o_busy,
    output logic                o_res_valid,
    output acte_pkg::t_result   o_result
);

    localparam int DIV_W = $clog2(TICKS_PER_SECOND);
    localparam logic [DIV_W-1:0] DIV_RELOAD = DIV_W'(TICKS_PER_SECOND - 1);
    localparam logic [DIV_W-1:0] DIV_HALF   = DIV_W'(TICKS_PER_SECOND / 2);

    // Input register
    logic             r_in_valid;
    acte_pkg::t_item  r_item;

    // Clock state
    logic [DIV_W-1:0]                r_div,   n_div;
    logic [acte_pkg::SEC_W-1:0]      r_sec,   n_sec;
    logic [acte_pkg::MIN_W-1:0]      r_min,   n_min;
    logic [acte_pkg::HOUR_W-1:0]     r_hour,  n_hour;
    logic [acte_pkg::COUNT_W-1:0]    r_motor_left, n_motor_left;
    logic [acte_pkg::COUNT_W-1:0]    r_lamp_left,  n_lamp_left;
    logic                            r_motor_active, n_motor_active;
    logic                            r_lamp_on,  n_lamp_on;

    // Intermediate values of the second step
    logic [6:0]                      sec_inc;
    logic [6:0]                      min_inc;
    logic [5:0]                      hour_inc;
    logic [acte_pkg::LIGHT_W:0]      lamp_on_level;
    logic                            half_pulse;
    logic                            sec_pulse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_item <= i_item;
        end
    end

    // Next state for the registered item
    always_comb begin
        n_div          = r_div;
        n_sec          = r_sec;
        n_min          = r_min;
        n_hour         = r_hour;
        n_motor_left   = r_motor_left;
        n_lamp_left    = r_lamp_left;
        n_motor_active = r_motor_active;
        n_lamp_on      = r_lamp_on;
        half_pulse     = 1'b0;
        sec_pulse      = 1'b0;
        sec_inc        = {1'b0, r_sec} + 7'd1;
        min_inc        = {1'b0, r_min} + 7'd1;
        hour_inc       = {1'b0, r_hour};
        lamp_on_level  = {1'b0, i_cfg.light_threshold} + {1'b0, i_cfg.light_hysteresis};

        if (r_in_valid) begin
            if (r_item.operation == acte_pkg::OP_SET_TIME) begin
                n_hour = r_item.new_hour;
                n_min  = r_item.new_minute;
                n_sec  = r_item.new_second;
            end else if (r_div != '0) begin
                half_pulse = (r_div == DIV_HALF);
                n_div      = r_div - DIV_W'(1);
            end else begin
                n_div     = DIV_RELOAD;
                sec_pulse = 1'b1;
                // Seconds / minutes / hours roll
                if (sec_inc >= acte_pkg::SIXTY) begin
                    n_sec = '0;
                    if (min_inc >= acte_pkg::SIXTY) begin
                        min_inc  = '0;
                        hour_inc = hour_inc + 6'd1;
                    end
                    if (hour_inc > {1'b0, i_cfg.hour_max}) begin
                        hour_inc = {1'b0, i_cfg.hour_min};
                    end
                    n_min  = min_inc[acte_pkg::MIN_W-1:0];
                    n_hour = hour_inc[acte_pkg::HOUR_W-1:0];
                    // Alarm compare at minute rollover
                    if (i_cfg.alarm_hour == n_hour && i_cfg.alarm_minute == n_min) begin
                        n_motor_left   = i_cfg.motor_seconds;
                        n_lamp_left    = i_cfg.lamp_seconds;
                        n_motor_active = 1'b1;
                    end
                end else begin
                    n_sec = sec_inc[acte_pkg::SEC_W-1:0];
                end
                // Motor countdown
                if (n_motor_left != '0) begin
                    if (n_motor_left == acte_pkg::COUNT_W'(1)) begin
                        n_motor_active = 1'b0;
                    end
                    n_motor_left = n_motor_left - acte_pkg::COUNT_W'(1);
                end
                // Lamp window with hysteresis
                if (n_lamp_left != '0) begin
                    priority if (n_lamp_left == acte_pkg::COUNT_W'(1)) begin
                        n_lamp_on = 1'b0;
                    end else if ({1'b0, r_item.sense_sample} > lamp_on_level) begin
                        n_lamp_on = 1'b1;
                    end else if (r_item.sense_sample < i_cfg.light_threshold) begin
                        n_lamp_on = 1'b0;
                    end else begin
                        // between the two levels the lamp keeps its state
                        n_lamp_on = r_lamp_on;
                    end
                    n_lamp_left = n_lamp_left - acte_pkg::COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div          <= '0;
            r_sec          <= '0;
            r_min          <= '0;
            r_hour         <= '0;
            r_motor_left   <= '0;
            r_lamp_left    <= '0;
            r_motor_active <= 1'b0;
            r_lamp_on      <= 1'b0;
        end else begin
            r_div          <= n_div;
            r_sec          <= n_sec;
            r_min          <= n_min;
            r_hour         <= n_hour;
            r_motor_left   <= n_motor_left;
            r_lamp_left    <= n_lamp_left;
            r_motor_active <= n_motor_active;
            r_lamp_on      <= n_lamp_on;
        end
    end

    // Result goes to the output queue in the same cycle
    assign o_busy      = r_in_valid;
    assign o_res_valid = r_in_valid;
    always_comb begin
        o_result.hour_now          = n_hour;
        o_result.minute_now        = n_min;
        o_result.second_now        = n_sec;
        o_result.motor_drive       = n_motor_active;
        o_result.lamp_drive        = n_lamp_on;
        o_result.half_second_pulse = half_pulse;
        o_result.second_pulse      = sec_pulse;
    end

endmodule

`default_nettype wire

// ===== design/acte_out_fifo.sv =====
// Small result queue that decouples the master stream from the update stage.
`timescale 1ns / 1ps
`default_nettype none

module acte_out_fifo (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_push,
    input  acte_pkg::t_result                 i_data,
    input  wire                               i_pop,
    output logic                              o_valid,
    output acte_pkg::t_result                 o_data,
    output logic [acte_pkg::OQ_CNT_W-1:0]     o_count
);

    acte_pkg::t_result                 r_mem [acte_pkg::OQ_DEPTH];
    logic [acte_pkg::OQ_PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [acte_pkg::OQ_PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [acte_pkg::OQ_CNT_W-1:0]     r_count,  n_count;
    logic                              do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Pointer and fill tracking
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == acte_pkg::OQ_PTR_W'(acte_pkg::OQ_DEPTH - 1)) ?
                       '0 : r_wr_ptr + acte_pkg::OQ_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == acte_pkg::OQ_PTR_W'(acte_pkg::OQ_DEPTH - 1)) ?
                       '0 : r_rd_ptr + acte_pkg::OQ_PTR_W'(1);
        end
        unique case ({i_push, do_pop})
            2'b10:   n_count = r_count + acte_pkg::OQ_CNT_W'(1);
            2'b01:   n_count = r_count - acte_pkg::OQ_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/alarm_clock_tick_engine.sv =====
// Top level of the alarm clock tick engine.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tdata: item fields, tuser: operation
//  m_axis    out        tvalid / tready        tdata: time, drives, pulses
//  cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per clock while s_axis tready is high. An accepted item is held in the
// input register; in the cycle after acceptance the clock state is updated and its
// result written into a three-entry output queue, which offers it on m_axis.
// s_axis tready depends only on registers (queue fill plus the input stage);
// a stalled m_axis lets up to three results collect before input is held off.
// Synchronous active-low reset clears clock state and queue and resets the config.
`timescale 1ns / 1ps
`default_nettype none

module alarm_clock_tick_engine #(
    parameter int TICKS_PER_SECOND = acte_pkg::TICKS_PER_SECOND_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // sense_sample[9:0], new_hour[14:10], new_minute[20:15], new_second[26:21]
    input  wire  [acte_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // operation[0]
    input  wire                                 s_axis_tuser,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // hour_now[4:0], minute_now[10:5], second_now[16:11], motor_drive[17],
    // lamp_drive[18], half_second_pulse[19], second_pulse[20]
    output logic [acte_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [acte_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [acte_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    acte_pkg::t_cfg                    cfg;
    acte_pkg::t_item                   item;
    acte_pkg::t_result                 res;
    acte_pkg::t_result                 out_res;
    logic                              res_valid;
    logic                              stage_busy;
    logic [acte_pkg::OQ_CNT_W-1:0]     oq_count;
    logic [acte_pkg::OQ_CNT_W:0]       in_flight;
    logic                              in_accept;

    // Unpack the input transaction
    always_comb begin
        item.operation    = acte_pkg::t_op'(s_axis_tuser);
        item.sense_sample = s_axis_tdata[9:0];
        item.new_hour     = s_axis_tdata[14:10];
        item.new_minute   = s_axis_tdata[20:15];
        item.new_second   = s_axis_tdata[26:21];
    end

    // Room for the item in the queue once the input stage drains
    assign in_flight     = {1'b0, oq_count} + {{acte_pkg::OQ_CNT_W{1'b0}}, stage_busy};
    assign s_axis_tready = (in_flight < (acte_pkg::OQ_CNT_W + 1)'(acte_pkg::OQ_DEPTH));
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    acte_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    acte_step #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_item      (item),
        .i_cfg       (cfg),
        .o_busy      (stage_busy),
        .o_res_valid (res_valid),
        .o_result    (res)
    );

    acte_out_fifo u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res),
        .o_count (oq_count)
    );

    // Pack the output transaction
    assign m_axis_tdata = {{(acte_pkg::M_TDATA_W - acte_pkg::RESULT_W){1'b0}}, out_res};

endmodule

`default_nettype wire

// ===== design/acte_checker.sv =====
// Port-level checks for the alarm clock tick engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module acte_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                s_axis_tready,
    input wire [acte_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready
);

    // Queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Input backpressure only happens with results waiting
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held off with no result pending");

    // Half-second and second pulses never coincide
    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[19] && m_axis_tdata[20]))
        else $error("half-second and second pulse together");

endmodule

bind alarm_clock_tick_engine acte_checker u_acte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
